// ----- rtl/itoa_pkg.sv -----
// ----------------------------------------------------------------------------
// itoa_pkg: shared types and helpers for the integer to ASCII converter
// Character codes, controller/datapath command and status structs, digit
// encoding and radix clamping.
// ----------------------------------------------------------------------------
package itoa_pkg;

  localparam int unsigned ValueWidth  = 32;
  localparam int unsigned RadixWidth  = 6;
  localparam int unsigned CharWidth   = 7;
  localparam int unsigned MaxDigits   = 32;
  localparam int unsigned DigitIdxW   = $clog2(MaxDigits);
  localparam int unsigned DigitCntW   = $clog2(MaxDigits + 1);

  // Quotient bits resolved per divider cycle, and divider steps per digit.
  localparam int unsigned BitsPerStep = 8;
  localparam int unsigned DivSteps    = ValueWidth / BitsPerStep;
  localparam int unsigned StepCntW    = $clog2(DivSteps);

  localparam logic [CharWidth-1:0]  CharZero       = 7'd48;
  localparam logic [CharWidth-1:0]  CharMinus      = 7'd45;
  localparam logic [CharWidth-1:0]  CharLetterBase = 7'd87;  // 'a' - 10
  localparam logic [RadixWidth-1:0] RadixDecimal   = 6'd10;
  localparam logic [RadixWidth-1:0] RadixMin       = 6'd2;
  localparam logic [RadixWidth-1:0] RadixMax       = 6'd36;

  typedef enum logic [2:0] {
    StIdle = 3'b001,
    StDiv  = 3'b010,
    StEmit = 3'b100
  } itoa_state_e;

  typedef struct packed {
    logic load;       // capture a new transaction
    logic step;       // run one divider step
    logic step_last;  // final divider cycle of the current digit
    logic emit;       // load the next character into the output register
  } itoa_cmd_t;

  typedef struct packed {
    logic div_done;   // quotient is zero and at least one digit is stored
    logic out_free;   // output register can take a character this cycle
    logic emit_done;  // sign and all digits have been sent
  } itoa_sts_t;

  function automatic logic [CharWidth-1:0] digit_char(input logic [RadixWidth-1:0] d);
    logic [CharWidth-1:0] dw;
    dw = CharWidth'(d);
    if (d >= RadixDecimal) begin
      return dw + CharLetterBase;
    end
    return dw + CharZero;
  endfunction

  function automatic logic [RadixWidth-1:0] clamp_radix(input logic [RadixWidth-1:0] r);
    if (r < RadixMin) begin
      return RadixMin;
    end
    if (r > RadixMax) begin
      return RadixMax;
    end
    return r;
  endfunction

endpackage

// ----- rtl/integer_to_ascii_radix.sv -----
// ----------------------------------------------------------------------------
// integer_to_ascii_radix: 32-bit integer to ASCII text in radix 2..36
// Top level joining the sequencing controller and the conversion datapath.
// ----------------------------------------------------------------------------
// One transaction in carries a 32-bit value, a radix and a signed/unsigned
// flag; it produces 1 to 32 output transactions, one ASCII character each,
// most significant first, with last high on the final character. Digits above
// nine are lower-case letters, zero gives "0", and a leading '-' appears only
// for a signed negative value in radix ten (other radices print the magnitude
// without sign). Radix codes 0 and 1 act as 2, codes above 36 act as 36.
// Operation: the input is accepted into the datapath, then each digit is
// divided out by the shared divider (8 quotient bits per cycle over the
// 32-bit word), a zero quotient ends the division, the characters are loaded
// into the output register in turn, held while the receiver stalls, and the
// controller then returns to idle.
// in_stall_o is high from the cycle after acceptance until the controller
// is back in idle after loading the last character into the output register;
// that character may still be waiting while the next transaction is accepted.
module integer_to_ascii_radix (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [itoa_pkg::ValueWidth-1:0]  value_i,
  input  logic [itoa_pkg::RadixWidth-1:0]  radix_i,
  input  logic                             treat_unsigned_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [itoa_pkg::CharWidth-1:0]   char_code_o,
  output logic                             last_o
);
  import itoa_pkg::*;

  itoa_cmd_t cmd;
  itoa_sts_t sts;

  // Controller: idle / divide / emit sequencing, step counter.
  itoa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Datapath: input capture (payload is sampled on the accepting edge),
  // divider, digit store and output register.
  itoa_datapath u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .value_i          (value_i),
    .radix_i          (radix_i),
    .treat_unsigned_i (treat_unsigned_i),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .char_code_o      (char_code_o),
    .last_o           (last_o)
  );

endmodule

// ----- rtl/itoa_ctrl.sv -----
// ----------------------------------------------------------------------------
// itoa_ctrl: sequencing controller
// Accepts a transaction, runs the divider digit by digit, then drives the
// character emission until the sign and all digits are out.
// ----------------------------------------------------------------------------
module itoa_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  itoa_pkg::itoa_sts_t sts_i,
  output itoa_pkg::itoa_cmd_t cmd_o
);
  import itoa_pkg::*;

  itoa_state_e         state_q, state_d;
  logic [StepCntW-1:0] cnt_q, cnt_d;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          cnt_d      = '0;
          state_d    = StDiv;
        end
      end
      StDiv: begin
        if (cnt_q == '0 && sts_i.div_done) begin
          state_d = StEmit;
        end else begin
          cmd_o.step      = 1'b1;
          cmd_o.step_last = (cnt_q == StepCntW'(DivSteps - 1));
          cnt_d           = cnt_q + 1'b1;
        end
      end
      StEmit: begin
        if (sts_i.emit_done) begin
          state_d = StIdle;
        end else if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  assign in_stall_o = (state_q != StIdle);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // Leaving emission only once everything is sent.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StEmit && state_d == StIdle) |-> sts_i.emit_done)
    else $error("emission ended early");

  // A digit never finishes in the middle of the step counter.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.step_last |=> (cnt_q == '0))
    else $error("step counter out of phase");

  // No divider work outside the division phase.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.step |-> (state_q == StDiv && !cmd_o.emit))
    else $error("divider stepped outside division");

endmodule

// ----- rtl/itoa_datapath.sv -----
// ----------------------------------------------------------------------------
// itoa_datapath: divider, digit store and output register
// Radix-r long division eight bits per cycle; remainders are stored as digits
// and read back most significant first into the output register.
// ----------------------------------------------------------------------------
module itoa_datapath (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic [itoa_pkg::ValueWidth-1:0]      value_i,
  input  logic [itoa_pkg::RadixWidth-1:0]      radix_i,
  input  logic                                 treat_unsigned_i,
  input  itoa_pkg::itoa_cmd_t                  cmd_i,
  output itoa_pkg::itoa_sts_t                  sts_o,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [itoa_pkg::CharWidth-1:0]       char_code_o,
  output logic                                 last_o
);
  import itoa_pkg::*;

  logic [ValueWidth-1:0] work_q, work_d;
  logic [RadixWidth-1:0] rem_q, rem_d;
  logic [RadixWidth-1:0] radix_q;
  logic [DigitCntW-1:0]  nd_q;
  logic                  sign_pend_q;
  logic                  out_valid_q;
  logic [CharWidth-1:0]  char_q;
  logic                  last_q;
  logic [RadixWidth-1:0] digits_q [MaxDigits];

  logic                  negative;
  logic [ValueWidth-1:0] magnitude;
  logic [RadixWidth-1:0] radix_c;
  logic [DigitCntW-1:0]  rd_idx;

  assign negative  = !treat_unsigned_i && value_i[ValueWidth-1];
  assign magnitude = negative ? (ValueWidth'(0) - value_i) : value_i;
  assign radix_c   = clamp_radix(radix_i);
  assign rd_idx    = nd_q - 1'b1;

  // Restoring division: shift dividend bits out the top, quotient bits in.
  always_comb begin
    logic [RadixWidth:0] t;
    work_d = work_q;
    rem_d  = rem_q;
    t      = '0;
    for (int i = 0; i < BitsPerStep; i++) begin
      t      = {rem_d, work_d[ValueWidth-1]};
      work_d = {work_d[ValueWidth-2:0], 1'b0};
      if (t >= {1'b0, radix_q}) begin
        t         = t - {1'b0, radix_q};
        work_d[0] = 1'b1;
      end
      rem_d = t[RadixWidth-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      work_q      <= '0;
      rem_q       <= '0;
      radix_q     <= RadixMin;
      nd_q        <= '0;
      sign_pend_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        work_q      <= magnitude;
        rem_q       <= '0;
        radix_q     <= radix_c;
        nd_q        <= '0;
        sign_pend_q <= negative && (radix_c == RadixDecimal);
      end else if (cmd_i.step) begin
        work_q <= work_d;
        rem_q  <= cmd_i.step_last ? '0 : rem_d;
        if (cmd_i.step_last) begin
          nd_q <= nd_q + 1'b1;
        end
      end else if (cmd_i.emit) begin
        if (sign_pend_q) begin
          sign_pend_q <= 1'b0;
        end else begin
          nd_q <= rd_idx;
        end
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.step && cmd_i.step_last) begin
      digits_q[nd_q[DigitIdxW-1:0]] <= rem_d;
    end
    if (cmd_i.emit) begin
      if (sign_pend_q) begin
        char_q <= CharMinus;
        last_q <= 1'b0;
      end else begin
        char_q <= digit_char(digits_q[rd_idx[DigitIdxW-1:0]]);
        last_q <= (nd_q == DigitCntW'(1));
      end
    end
  end

  assign sts_o.div_done  = (work_q == '0) && (nd_q != '0);
  assign sts_o.out_free  = !out_valid_q || !out_stall_i;
  assign sts_o.emit_done = (nd_q == '0) && !sign_pend_q;

  assign out_valid_o = out_valid_q;
  assign char_code_o = char_q;
  assign last_o      = last_q;

  // Remainder stays a valid digit of the current radix.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rem_q < radix_q)
    else $error("remainder not below radix");

  // Digit count never exceeds the store depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    nd_q <= DigitCntW'(MaxDigits))
    else $error("digit store overflow");

  // A stalled character is never overwritten.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> (!out_valid_q || !out_stall_i))
    else $error("output register overwritten while stalled");

endmodule

// ----- verif/tb_integer_to_ascii_radix.sv -----
// ----------------------------------------------------------------------------
// tb_integer_to_ascii_radix: self-checking testbench for the radix converter
// Drives numbers with random radix and signedness, predicts the ASCII text of
// each one and checks every output character and its last flag in order.
// ----------------------------------------------------------------------------
module tb_integer_to_ascii_radix;
  import itoa_pkg::*;

  // Longest stretch with no transaction on either side before the run is
  // declared hung. A 32-digit binary number is fully divided before its
  // first character, and the long receiver hold-off adds LongHoldCycles.
  localparam int unsigned WatchdogLimit  = 2000;
  localparam int unsigned LongHoldCycles = 300;
  // Quiet time after the last character: one slow conversion and then some.
  localparam int unsigned SettleCycles   = 200;
  localparam int unsigned MaxReported    = 10;

  // One predicted output character.
  typedef struct packed {
    logic [CharWidth-1:0] code;
    logic                 last;
  } text_char_t;

  logic                  clk      = 1'b0;
  logic                  rst_n    = 1'b0;
  logic                  in_valid = 1'b0;
  logic [ValueWidth-1:0] value    = '0;
  logic [RadixWidth-1:0] radix    = '0;
  logic                  as_unsigned = 1'b0;
  logic                  out_stall = 1'b0;

  logic                  in_stall;
  logic                  out_valid;
  logic [CharWidth-1:0]  char_code;
  logic                  last;

  // Characters still owed by the block, oldest first.
  text_char_t pending_chars[$];

  // Idle-burst enables for the two sides, and the long hold-off request.
  bit in_gaps_on  = 1'b0;
  bit out_gaps_on = 1'b0;
  bit hold_req    = 1'b0;

  int unsigned fail_cnt      = 0;
  int unsigned numbers_sent  = 0;
  int unsigned chars_checked = 0;
  int unsigned minus_cnt     = 0;
  int unsigned clamp_cnt     = 0;
  int unsigned idle_cycles   = 0;

  integer_to_ascii_radix u_top (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .value_i          (value),
    .radix_i          (radix),
    .treat_unsigned_i (as_unsigned),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .char_code_o      (char_code),
    .last_o           (last)
  );

  always #5 clk = ~clk;

  // --------------------------------------------------------------------------
  // Text predictor: works out the characters one number must produce and
  // queues them. Radix codes outside 2..36 saturate to the nearest end; a
  // signed negative number is converted through its magnitude, and only
  // radix ten puts a minus sign in front.
  // --------------------------------------------------------------------------
  function automatic void predict_text(input logic [ValueWidth-1:0] word,
                                       input logic [RadixWidth-1:0] radix_code,
                                       input logic                  read_unsigned);
    logic [RadixWidth-1:0] base;
    logic [ValueWidth-1:0] mag;
    logic                  negative;
    logic [RadixWidth-1:0] digits[$];
    text_char_t            ch;

    if (radix_code < RadixMin) begin
      base = RadixMin;
    end else if (radix_code > RadixMax) begin
      base = RadixMax;
    end else begin
      base = radix_code;
    end
    if (base != radix_code) clamp_cnt++;

    negative = !read_unsigned && word[ValueWidth-1];
    // Two's complement negate; the most negative word maps onto itself, which
    // read unsigned is exactly its magnitude.
    mag = negative ? (~word + 1'b1) : word;

    // Least significant digit first, pushed to the front so the queue ends up
    // most significant first. Zero still yields one digit.
    do begin
      digits.push_front(RadixWidth'(mag % ValueWidth'(base)));
      mag = mag / ValueWidth'(base);
    end while (mag != '0);

    if (negative && base == RadixDecimal) begin
      ch.code = CharMinus;
      ch.last = 1'b0;
      pending_chars.push_back(ch);
      minus_cnt++;
    end

    foreach (digits[i]) begin
      if (digits[i] >= RadixDecimal) begin
        ch.code = CharWidth'(digits[i]) + CharLetterBase;
      end else begin
        ch.code = CharWidth'(digits[i]) + CharZero;
      end
      ch.last = (i == digits.size() - 1);
      pending_chars.push_back(ch);
    end
  endfunction

  // --------------------------------------------------------------------------
  // Sender: offers one number and holds it until the block takes it. Starts
  // and returns at a falling edge; valid stays high on return so back-to-back
  // calls keep the input busy. An optional idle burst comes first.
  // --------------------------------------------------------------------------
  task automatic send_number(input logic [ValueWidth-1:0] v,
                             input logic [RadixWidth-1:0] r,
                             input logic                  u);
    if (in_gaps_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_valid    <= 1'b1;
    value       <= v;
    radix       <= r;
    as_unsigned <= u;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    // Transaction taken at this edge.
    predict_text(v, r, u);
    numbers_sent++;
    @(negedge clk);
  endtask

  // Random number with a bias toward the interesting corners.
  task automatic send_random_number();
    logic [ValueWidth-1:0] v;
    logic [RadixWidth-1:0] r;
    int unsigned           pick;

    pick = $urandom_range(0, 9);
    case (pick)
      0, 1, 2, 3: v = $urandom;
      4, 5:       v = $urandom_range(0, 99);
      6:          v = -ValueWidth'($urandom_range(1, 1000));
      7:          v = (ValueWidth'(1) << $urandom_range(0, 31)) - $urandom_range(0, 1);
      8: begin
        case ($urandom_range(0, 3))
          0:       v = 32'h0000_0000;
          1:       v = 32'h8000_0000;
          2:       v = 32'h7fff_ffff;
          default: v = 32'hffff_ffff;
        endcase
      end
      default:    v = {1'b1, 31'($urandom)};
    endcase

    pick = $urandom_range(0, 9);
    case (pick)
      0, 1, 2:       r = RadixDecimal;
      3, 4, 5, 6, 7: r = RadixWidth'($urandom_range(2, 36));
      8: begin
        case ($urandom_range(0, 3))
          0:       r = RadixMin;
          1:       r = 6'd8;
          2:       r = 6'd16;
          default: r = RadixMax;
        endcase
      end
      // Whole field, including the codes that saturate.
      default:       r = RadixWidth'($urandom_range(0, 63));
    endcase

    send_number(v, r, 1'($urandom_range(0, 1)));
  endtask

  // --------------------------------------------------------------------------
  // Output checker: every accepted character is compared against the oldest
  // prediction.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    text_char_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_chars.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= MaxReported) begin
          $display("ERROR: unexpected character 0x%02h last=%0b", char_code, last);
        end
      end else begin
        want = pending_chars.pop_front();
        chars_checked++;
        if (char_code !== want.code || last !== want.last) begin
          fail_cnt++;
          if (fail_cnt <= MaxReported) begin
            $display("ERROR: character %0d expected 0x%02h '%c' last=%0b, got 0x%02h last=%0b",
                     chars_checked, want.code, want.code, want.last, char_code, last);
          end
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver stall: short random bursts when enabled, plus a long hold-off on
  // request, counted down here.
  // --------------------------------------------------------------------------
  initial begin
    int unsigned hold_left;
    int unsigned burst_left;
    hold_left  = 0;
    burst_left = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = LongHoldCycles;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (burst_left > 0) begin
        out_stall <= 1'b1;
        burst_left--;
      end else if (out_gaps_on && $urandom_range(0, 3) == 0) begin
        out_stall  <= 1'b1;
        burst_left = $urandom_range(0, 3);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog: a long run of cycles without any transaction means a hang.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WatchdogLimit) begin
        $display("ERROR: no transaction for %0d cycles, %0d characters outstanding",
                 idle_cycles, pending_chars.size());
        $display("tb_integer_to_ascii_radix failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Field extremes, digit boundaries, sign handling and radix saturation.
  task automatic test_directed_cases();
    in_gaps_on  = 1'b1;
    out_gaps_on = 1'b1;
    send_number(32'd0, RadixDecimal, 1'b0);          // zero, signed
    send_number(32'd0, RadixMin, 1'b1);              // zero, unsigned
    send_number(32'hffff_ffff, RadixMin, 1'b1);      // 32 binary ones
    send_number(32'hffff_ffff, RadixDecimal, 1'b0);  // -1
    send_number(32'hffff_ffff, RadixDecimal, 1'b1);  // 4294967295
    send_number(32'h8000_0000, RadixDecimal, 1'b0);  // most negative, signed
    send_number(32'h8000_0000, RadixMin, 1'b0);      // magnitude in binary
    send_number(32'h8000_0000, 6'd16, 1'b0);         // magnitude in hex, no sign
    send_number(32'h7fff_ffff, RadixMax, 1'b0);      // largest positive, radix 36
    send_number(32'hffff_ffff, RadixMax, 1'b1);
    send_number(32'd9, RadixDecimal, 1'b1);          // last decimal digit
    send_number(32'd10, 6'd16, 1'b1);                // first letter
    send_number(32'd35, RadixMax, 1'b0);             // last letter
    send_number(32'd36, RadixMax, 1'b0);             // "10" in radix 36
    send_number(32'hffff_fffb, 6'd3, 1'b0);          // -5 in radix 3, no sign
    send_number(32'd5, 6'd0, 1'b1);                  // radix code 0 saturates to 2
    send_number(32'd5, 6'd1, 1'b0);                  // radix code 1 saturates to 2
    send_number(32'd71, 6'd37, 1'b1);                // just above 36
    send_number(32'hdead_beef, 6'd63, 1'b1);         // all-ones radix code
    send_number(32'hdead_beef, 6'd63, 1'b0);
    send_number(32'h1234_5678, 6'd8, 1'b1);
    in_valid <= 1'b0;
  endtask

  // Bulk random numbers with idle bursts on both sides.
  task automatic test_random_mix();
    in_gaps_on  = 1'b1;
    out_gaps_on = 1'b1;
    repeat (110) send_random_number();
    in_valid <= 1'b0;
  endtask

  // The receiver holds off for a long stretch while numbers keep coming, so
  // the output register fills and the block stalls its input.
  task automatic test_output_backpressure();
    in_gaps_on  = 1'b0;
    out_gaps_on = 1'b0;
    hold_req    = 1'b1;
    repeat (20) send_random_number();
    in_valid <= 1'b0;
  endtask

  // No idling on either side: back-to-back numbers at full rate.
  task automatic test_full_rate();
    in_gaps_on  = 1'b0;
    out_gaps_on = 1'b0;
    repeat (60) send_random_number();
    in_valid <= 1'b0;
  endtask

  initial begin
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_directed_cases();
    test_random_mix();
    test_output_backpressure();
    test_full_rate();

    // Drain, then stay quiet long enough to catch any stray character.
    while (pending_chars.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
    if (pending_chars.size() != 0) begin
      fail_cnt++;
      $display("ERROR: %0d predicted characters never arrived", pending_chars.size());
    end

    $display("Converted %0d numbers into %0d checked characters", numbers_sent, chars_checked);
    $display("  %0d with a minus sign, %0d with a saturated radix code, %0d errors",
             minus_cnt, clamp_cnt, fail_cnt);
    if (fail_cnt == 0) begin
      $display("tb_integer_to_ascii_radix passed");
    end else begin
      $display("tb_integer_to_ascii_radix failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/itoa_pkg.sv
rtl/itoa_ctrl.sv
rtl/itoa_datapath.sv
rtl/integer_to_ascii_radix.sv
verif/tb_integer_to_ascii_radix.sv
